/* src/decimal_digit_formatter_assert.svh */
// Assertion helpers for the formatter RTL, included by ddf_emitter.
`ifndef DECIMAL_DIGIT_FORMATTER_ASSERT_SVH
`define DECIMAL_DIGIT_FORMATTER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define DDF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("formatter check failed");

// Antecedent in one cycle implies consequent in the next.
`define DDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("formatter check failed");

`endif

/* src/ddf_pkg.sv */
`default_nettype none
package ddf_pkg;

  localparam int VALUE_W        = 32;
  localparam int CNT_W          = 4;
  localparam int COL_W          = 8;
  localparam int ROW_W          = 8;
  localparam int FONT_W         = 2;
  localparam int CODE_W         = 6;
  localparam int DIG_W          = 4;
  localparam int STAGES         = 4;
  localparam int STEPS          = VALUE_W / STAGES;
  localparam int MAX_DIGITS_DEF = 10;

  localparam logic [CODE_W-1:0] CHAR_SPACE = 6'd32;
  localparam logic [CODE_W-1:0] CHAR_ZERO  = 6'd48;

  localparam logic [FONT_W-1:0] FONT_12 = 2'd0;
  localparam logic [FONT_W-1:0] FONT_16 = 2'd1;

  localparam logic [COL_W-1:0] STEP_12 = 8'd6;
  localparam logic [COL_W-1:0] STEP_16 = 8'd8;
  localparam logic [COL_W-1:0] STEP_32 = 8'd16;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [COL_W-1:0]  start;
    logic [ROW_W-1:0]  row;
    logic [FONT_W-1:0] font;
  } meta_t;

  // Column advance per character: half the font height; unused codes 2 and 3 step as a 32-high font.
  function automatic logic [COL_W-1:0] column_step(input logic [FONT_W-1:0] font);
    logic [COL_W-1:0] s;
    case (font)
      FONT_12: s = STEP_12;
      FONT_16: s = STEP_16;
      default: s = STEP_32;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

/* src/decimal_digit_formatter.sv */
// Decimal digit formatter: turns a 32-bit unsigned value into a run of
// ASCII characters, most significant first, leading zeros shown as spaces
// (the final position always shows its digit).
// Input channel in_*: value, digit count (saturated to MAX_DIGITS), start
// column, row and font select; accepted when in_valid and in_ready are high.
// Output channel out_*: one item per character with its code, column
// (start + half font height per position, mod 256), row, font and last flag.
// An accepted item passes through four shift-add conversion stages of
// eight bits each, is then loaded into the character sequencer, and each
// character is registered in the output reg before it is presented.
// The sequencer emits one character a cycle unless the output stalls; the
// conversion stages take an item every cycle unless back-pressured, and
// buffer up to four items while the sequencer is busy.
// Reset clears all valid flags; no item is in flight afterwards.
// When the receiver holds out_ready low the output register keeps its item,
// the sequencer and then the conversion stages fill and in_ready falls;
// nothing is dropped or repeated.
`default_nettype none
module decimal_digit_formatter
  import ddf_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [VALUE_W-1:0] in_value,
  input  wire logic [CNT_W-1:0]   in_digit_count,
  input  wire logic [COL_W-1:0]   in_start_column,
  input  wire logic [ROW_W-1:0]   in_row,
  input  wire logic [FONT_W-1:0]  in_font_select,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [CODE_W-1:0]       out_char_code,
  output logic [COL_W-1:0]        out_column,
  output logic [ROW_W-1:0]        out_row_out,
  output logic [FONT_W-1:0]       out_font_out,
  output logic                    out_last
);

  localparam int BCD_W = MAX_DIGITS * DIG_W;

  logic [STAGES:0]              v;
  logic [STAGES:0]              rdy;
  logic [STAGES:0][BCD_W-1:0]   bcd;
  logic [STAGES:0][VALUE_W-1:0] bin;
  meta_t [STAGES:0]             meta;

  assign v[0]              = in_valid;
  assign in_ready          = rdy[0];
  assign bcd[0]            = '0;
  assign bin[0]            = in_value;
  assign meta[0].count     = (in_digit_count > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
                                                                    : in_digit_count;
  assign meta[0].start     = in_start_column;
  assign meta[0].row       = in_row;
  assign meta[0].font      = in_font_select;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    ddf_dabble_stage #(
      .BCD_W(BCD_W)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (v[g]),
      .in_ready (rdy[g]),
      .in_bcd   (bcd[g]),
      .in_bin   (bin[g]),
      .in_meta  (meta[g]),
      .out_valid(v[g+1]),
      .out_ready(rdy[g+1]),
      .out_bcd  (bcd[g+1]),
      .out_bin  (bin[g+1]),
      .out_meta (meta[g+1])
    );
  end

  ddf_emitter #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_emitter (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (v[STAGES]),
    .in_ready     (rdy[STAGES]),
    .in_bcd       (bcd[STAGES]),
    .in_meta      (meta[STAGES]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code),
    .out_column   (out_column),
    .out_row      (out_row_out),
    .out_font     (out_font_out),
    .out_last     (out_last)
  );

endmodule
`default_nettype wire

/* src/ddf_dabble_stage.sv */
`default_nettype none
module ddf_dabble_stage
  import ddf_pkg::*;
#(
  parameter int BCD_W = MAX_DIGITS_DEF * DIG_W
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [BCD_W-1:0]   in_bcd,
  input  wire logic [VALUE_W-1:0] in_bin,
  input  wire meta_t              in_meta,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [BCD_W-1:0]        out_bcd,
  output logic [VALUE_W-1:0]      out_bin,
  output meta_t                   out_meta
);

  localparam int NDIG = BCD_W / DIG_W;

  logic               valid_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [VALUE_W-1:0] bin_r;
  meta_t              meta_r;
  logic [BCD_W-1:0]   bcd_nxt;
  logic [VALUE_W-1:0] bin_nxt;

  // STEPS rounds of add-3 then shift; digits above the top one fall off,
  // which keeps the value modulo 10^NDIG.
  always_comb begin
    logic [BCD_W-1:0]   b;
    logic [VALUE_W-1:0] v;
    b = in_bcd;
    v = in_bin;
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (b[d*DIG_W +: DIG_W] >= 4'd5) begin
          b[d*DIG_W +: DIG_W] = b[d*DIG_W +: DIG_W] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], v[VALUE_W-1]};
      v = {v[VALUE_W-2:0], 1'b0};
    end
    bcd_nxt = b;
    bin_nxt = v;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      bcd_r  <= bcd_nxt;
      bin_r  <= bin_nxt;
      meta_r <= in_meta;
    end
  end

  assign out_valid = valid_r;
  assign out_bcd   = bcd_r;
  assign out_bin   = bin_r;
  assign out_meta  = meta_r;

endmodule
`default_nettype wire

/* src/ddf_emitter.sv */
`default_nettype none
module ddf_emitter
  import ddf_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [MAX_DIGITS*DIG_W-1:0] in_bcd,
  input  wire meta_t                     in_meta,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [CODE_W-1:0]              out_char_code,
  output logic [COL_W-1:0]               out_column,
  output logic [ROW_W-1:0]               out_row,
  output logic [FONT_W-1:0]              out_font,
  output logic                           out_last
);

  `include "decimal_digit_formatter_assert.svh"

  localparam int BCD_W = MAX_DIGITS * DIG_W;

  logic              busy_r;
  logic [BCD_W-1:0]  digits_r;
  logic [CNT_W-1:0]  rem_r;
  logic [COL_W-1:0]  col_r;
  logic [COL_W-1:0]  step_r;
  logic [ROW_W-1:0]  row_r;
  logic [FONT_W-1:0] font_r;
  logic              shown_r;

  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [FONT_W-1:0] out_font_r;
  logic              out_last_r;

  logic              emit;
  logic              is_last;
  logic              load;
  logic [DIG_W-1:0]  digit;
  logic              blank;
  logic [CODE_W-1:0] code;
  logic [CNT_W-1:0]  gap;
  logic [BCD_W-1:0]  aligned;

  assign emit     = busy_r && (!out_valid_r || out_ready);
  assign is_last  = (rem_r == CNT_W'(1));
  assign in_ready = !busy_r || (emit && is_last);
  assign load     = in_valid && in_ready;

  // Most significant wanted digit is moved to the top nibble on load.
  assign gap     = CNT_W'(MAX_DIGITS) - in_meta.count;
  assign aligned = in_bcd << {gap, 2'b00};

  assign digit = digits_r[BCD_W-1 -: DIG_W];
  assign blank = !shown_r && !is_last && (digit == '0);
  assign code  = blank ? CHAR_SPACE : (CHAR_ZERO + {2'b00, digit});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load) begin
      busy_r <= (in_meta.count != '0);
    end else if (emit && is_last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits_r <= aligned;
      rem_r    <= in_meta.count;
      col_r    <= in_meta.start;
      step_r   <= column_step(in_meta.font);
      row_r    <= in_meta.row;
      font_r   <= in_meta.font;
      shown_r  <= 1'b0;
    end else if (emit) begin
      digits_r <= digits_r << DIG_W;
      rem_r    <= rem_r - CNT_W'(1);
      col_r    <= col_r + step_r;
      shown_r  <= shown_r || !blank;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_code_r <= code;
      out_col_r  <= col_r;
      out_row_r  <= row_r;
      out_font_r <= font_r;
      out_last_r <= is_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_code_r;
  assign out_column    = out_col_r;
  assign out_row       = out_row_r;
  assign out_font      = out_font_r;
  assign out_last      = out_last_r;

  `DDF_ASSERT_ALWAYS(a_rem_range, !busy_r || (rem_r != '0 && rem_r <= CNT_W'(MAX_DIGITS)))
  `DDF_ASSERT_NEXT(a_last_frees, emit && is_last && !load, !busy_r)
  `DDF_ASSERT_NEXT(a_emit_shows, emit, out_valid_r && (out_last_r == $past(is_last)))
  `DDF_ASSERT_ALWAYS(a_last_digit, !(out_valid_r && out_last_r) || (out_code_r != CHAR_SPACE))

endmodule
`default_nettype wire
